FILE: src/i2c_master_bit_engine_assert.svh
// Assertion helpers for the I2C master bit engine.
// I2CM_ASSERT checks a property outside reset; I2CM_ASSERT_NR checks it always.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`define I2CM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define I2CM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/i2cm_pkg.sv
package i2cm_pkg;

   // Request codes carried by req_type
   typedef enum logic [2:0] {
      REQ_START    = 3'd0,
      REQ_STOP     = 3'd1,
      REQ_WRITE    = 3'd2,
      REQ_WAIT_ACK = 3'd3,
      REQ_READ     = 3'd4
   } req_code_type;

   // Acknowledge status codes
   typedef enum logic [1:0] {
      ACK_OK      = 2'd0,
      ACK_TIMEOUT = 2'd1,
      ACK_NACK    = 2'd2
   } ack_status_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_HALF_PERIOD = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd2;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd255;
   localparam logic [2:0]  BIT_MSB           = 3'd7;

   // Engine phases, one-hot
   typedef enum logic [13:0] {
      PH_IDLE      = 14'h0001,
      PH_START_A   = 14'h0002,
      PH_START_B   = 14'h0004,
      PH_STOP_A    = 14'h0008,
      PH_WR_LOW    = 14'h0010,
      PH_WR_HIGH   = 14'h0020,
      PH_ACK_POLL  = 14'h0040,
      PH_ACK_HIGH  = 14'h0080,
      PH_ACK_LOW   = 14'h0100,
      PH_RD_LOW    = 14'h0200,
      PH_RD_HIGH   = 14'h0400,
      PH_RD_GAP    = 14'h0800,
      PH_RD_ACKCLK = 14'h1000,
      PH_RD_TAIL   = 14'h2000
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] req_type;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } req_item_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic [1:0] ack_status;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] half_period;
      logic [7:0]  ack_timeout;
   } cfg_type;

endpackage

FILE: src/i2cm_channels.sv
// Tick channel: one beat per engine tick
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] req_type;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_sample;

   modport source (output valid, cmd_valid, req_type, tx_byte, send_ack, sda_sample,
                   input ready);
   modport sink   (input valid, cmd_valid, req_type, tx_byte, send_ack, sda_sample,
                   output ready);
endinterface

// Line state channel: one beat per engine tick
interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_drive;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic [1:0] ack_status;

   modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
                   ack_status, input ready);
   modport sink   (input valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
                   ack_status, output ready);
endinterface

// Register write channel
interface i2cm_csr_if;
   logic                              valid;
   logic                              ready;
   logic                              index;
   logic [i2cm_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/i2cm_csr.sv
module i2cm_csr (
   input  logic              clock,
   input  logic              reset,
   i2cm_csr_if.sink          csr_bus,
   output i2cm_pkg::cfg_type cfg
);

   i2cm_pkg::cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_bus.ready = 1'b1;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            i2cm_pkg::CSR_HALF_PERIOD: cfg_in.half_period = csr_bus.data;
            i2cm_pkg::CSR_ACK_TIMEOUT: cfg_in.ack_timeout = csr_bus.data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= i2cm_pkg::HALF_PERIOD_RESET;
         cfg_ff.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/i2cm_core.sv
module i2cm_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2cm_pkg::req_item_type item,
   input  i2cm_pkg::cfg_type      cfg,
   output i2cm_pkg::rsp_item_type res
);

   i2cm_pkg::phase_type      phase_ff, phase_in;
   logic [2:0]               bit_index_ff, bit_index_in;
   logic [7:0]               shift_data_ff, shift_data_in;
   logic [15:0]              tick_count_ff, tick_count_in;
   logic [7:0]               timeout_ff, timeout_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   i2cm_pkg::ack_status_type status_ff, status_in;
   logic                     ack_choice_ff, ack_choice_in;
   logic [7:0]               rx_hold_ff, rx_hold_in;

   logic [15:0] tick_next;
   logic [2:0]  bit_dec;
   logic        done;

   assign tick_next = tick_count_ff + 16'd1;
   assign bit_dec   = bit_index_ff - 3'd1;

   // Next state for one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_data_in = shift_data_ff;
      tick_count_in = tick_count_ff;
      timeout_in    = timeout_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      status_in     = status_ff;
      ack_choice_in = ack_choice_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;

      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         // New command; unknown codes are dropped
         if (item.cmd_valid && item.req_type <= i2cm_pkg::REQ_READ) begin
            tick_count_in = '0;
            bit_index_in  = i2cm_pkg::BIT_MSB;
            unique case (item.req_type)
               i2cm_pkg::REQ_START: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_START_A;
               end
               i2cm_pkg::REQ_STOP: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_STOP_A;
               end
               i2cm_pkg::REQ_WRITE: begin
                  shift_data_in = item.tx_byte;
                  scl_in        = 1'b0;
                  sda_in        = item.tx_byte[i2cm_pkg::BIT_MSB];
                  phase_in      = i2cm_pkg::PH_WR_LOW;
               end
               i2cm_pkg::REQ_WAIT_ACK: begin
                  timeout_in = cfg.ack_timeout;
                  phase_in   = i2cm_pkg::PH_ACK_POLL;
               end
               default: begin
                  shift_data_in = '0;
                  ack_choice_in = item.send_ack;
                  scl_in        = 1'b0;
                  phase_in      = i2cm_pkg::PH_RD_LOW;
               end
            endcase
         end
      end else begin
         tick_count_in = tick_next;
         // End of a half period: advance the sequence
         if (tick_next >= cfg.half_period) begin
            tick_count_in = '0;
            unique case (phase_ff)
               i2cm_pkg::PH_START_A: begin
                  sda_in   = 1'b0;
                  phase_in = i2cm_pkg::PH_START_B;
               end
               i2cm_pkg::PH_START_B: begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
               i2cm_pkg::PH_STOP_A: begin
                  sda_in = 1'b1;
                  done   = 1'b1;
               end
               i2cm_pkg::PH_WR_LOW: begin
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_WR_HIGH;
               end
               i2cm_pkg::PH_WR_HIGH: begin
                  scl_in = 1'b0;
                  if (bit_index_ff == '0) begin
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end else begin
                     bit_index_in = bit_dec;
                     sda_in       = shift_data_ff[bit_dec];
                     phase_in     = i2cm_pkg::PH_WR_LOW;
                  end
               end
               i2cm_pkg::PH_ACK_POLL: begin
                  if (timeout_ff == '0) begin
                     status_in = i2cm_pkg::ACK_TIMEOUT;
                     done      = 1'b1;
                  end else if (!item.sda_sample) begin
                     scl_in   = 1'b1;
                     phase_in = i2cm_pkg::PH_ACK_HIGH;
                  end else begin
                     timeout_in = timeout_ff - 8'd1;
                  end
               end
               i2cm_pkg::PH_ACK_HIGH: begin
                  if (item.sda_sample) begin
                     status_in = i2cm_pkg::ACK_NACK;
                     done      = 1'b1;
                  end else begin
                     scl_in   = 1'b0;
                     phase_in = i2cm_pkg::PH_ACK_LOW;
                  end
               end
               i2cm_pkg::PH_ACK_LOW: begin
                  status_in = i2cm_pkg::ACK_OK;
                  done      = 1'b1;
               end
               i2cm_pkg::PH_RD_LOW: begin
                  // sample as SCL rises
                  scl_in = 1'b1;
                  if (item.sda_sample) begin
                     shift_data_in[bit_index_ff] = 1'b1;
                  end
                  phase_in = i2cm_pkg::PH_RD_HIGH;
               end
               i2cm_pkg::PH_RD_HIGH: begin
                  scl_in = 1'b0;
                  if (bit_index_ff == '0) begin
                     phase_in = i2cm_pkg::PH_RD_GAP;
                  end else begin
                     bit_index_in = bit_dec;
                     phase_in     = i2cm_pkg::PH_RD_LOW;
                  end
               end
               i2cm_pkg::PH_RD_GAP: begin
                  sda_in   = !ack_choice_ff;
                  scl_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_RD_ACKCLK;
               end
               i2cm_pkg::PH_RD_ACKCLK: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b1;
                  phase_in = i2cm_pkg::PH_RD_TAIL;
               end
               i2cm_pkg::PH_RD_TAIL: begin
                  rx_hold_in = shift_data_ff;
                  done       = 1'b1;
               end
               default: done = 1'b1;
            endcase
            if (done) begin
               phase_in     = i2cm_pkg::PH_IDLE;
               bit_index_in = i2cm_pkg::BIT_MSB;
            end
         end
      end
   end

   // State registers advance once per tick beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         bit_index_ff  <= i2cm_pkg::BIT_MSB;
         shift_data_ff <= '0;
         tick_count_ff <= '0;
         timeout_ff    <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         status_ff     <= i2cm_pkg::ACK_OK;
         ack_choice_ff <= 1'b0;
         rx_hold_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_data_ff <= shift_data_in;
         tick_count_ff <= tick_count_in;
         timeout_ff    <= timeout_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         status_ff     <= status_in;
         ack_choice_ff <= ack_choice_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   // Result of this tick
   always_comb begin
      res.scl_drive  = scl_in;
      res.sda_drive  = sda_in;
      res.busy_res   = (phase_in != i2cm_pkg::PH_IDLE);
      res.done_res   = done;
      res.rx_byte    = rx_hold_in;
      res.ack_status = status_in;
   end

endmodule

FILE: src/i2c_master_bit_engine.sv
// I2C master bit engine.
// req_bus: one beat per engine tick, carrying an optional command (start, stop,
//   write byte, wait ack, read byte) and the sampled SDA level. A command is
//   taken only when the engine is idle; otherwise it is ignored.
// rsp_bus: exactly one beat per req_bus beat, in order, with the SCL/SDA drive
//   levels, busy, a one-beat done flag, the last read byte and ack status.
// csr_bus: register writes, always ready. Index 0 half period in ticks,
//   index 1 ack timeout in half periods. Write only while idle.
// Pipeline: a tick beat is held in the input register, then its result in the
//   output register (valid from then on). One beat per cycle sustained while
//   rsp_bus.ready is high: an input register and an output register each hold
//   one beat, and the engine state advances whenever a beat moves between them.
// Stall: if rsp_bus.ready stays low, the result is held, one more tick beat is
//   stored, then req_bus.ready drops until the result is taken.
// Reset (synchronous): engine idle, SCL and SDA released, registers back to
//   half period 2 and ack timeout 255, both pipeline registers empty.
module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_bus,
   i2cm_rsp_if.source  rsp_bus,
   i2cm_csr_if.sink    csr_bus
);

   logic                   in_valid_ff, in_valid_in;
   i2cm_pkg::req_item_type in_item_ff, in_item_in;
   logic                   out_valid_ff, out_valid_in;
   i2cm_pkg::rsp_item_type out_item_ff;
   i2cm_pkg::rsp_item_type core_res;
   i2cm_pkg::cfg_type      cfg;
   logic                   step;

   i2cm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   i2cm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg),
      .res   (core_res)
   );

   // Input register
   assign step          = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step;
   assign in_valid_in   = req_bus.ready ? req_bus.valid : in_valid_ff;

   always_comb begin
      in_item_in.cmd_valid  = req_bus.cmd_valid;
      in_item_in.req_type   = req_bus.req_type;
      in_item_in.tx_byte    = req_bus.tx_byte;
      in_item_in.send_ack   = req_bus.send_ack;
      in_item_in.sda_sample = req_bus.sda_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff <= in_item_in;
      end
   end

   // Output register
   assign out_valid_in = step ? 1'b1 : (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_item_ff <= core_res;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.scl_drive  = out_item_ff.scl_drive;
   assign rsp_bus.sda_drive  = out_item_ff.sda_drive;
   assign rsp_bus.busy_res   = out_item_ff.busy_res;
   assign rsp_bus.done_res   = out_item_ff.done_res;
   assign rsp_bus.rx_byte    = out_item_ff.rx_byte;
   assign rsp_bus.ack_status = out_item_ff.ack_status;

endmodule

FILE: src/i2cm_checker.sv
`include "i2c_master_bit_engine_assert.svh"

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       scl_drive,
   input logic       sda_drive,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] rx_byte,
   input logic [1:0] ack_status
);

   logic [13:0] rsp_payload;

   assign rsp_payload = {scl_drive, sda_drive, busy_res, done_res, rx_byte, ack_status};

   // A stalled result beat is held unchanged
   `I2CM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp beat changed while stalled")

   // Completion leaves the engine idle
   `I2CM_ASSERT(a_done_idle, clock, reset, rsp_valid && done_res |-> !busy_res, "done reported while still busy")

   // Status code 3 is never produced
   `I2CM_ASSERT(a_status_code, clock, reset, rsp_valid |-> ack_status != 2'd3, "bad ack status code")

   // Reset empties the output register
   `I2CM_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid straight after reset")

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .scl_drive  (rsp_bus.scl_drive),
   .sda_drive  (rsp_bus.sda_drive),
   .busy_res   (rsp_bus.busy_res),
   .done_res   (rsp_bus.done_res),
   .rx_byte    (rsp_bus.rx_byte),
   .ack_status (rsp_bus.ack_status)
);
